@@ hdl/vsa_pkg.sv @@
// Package: types, constants and operation codes of the voice slot allocator.
`default_nettype none
package vsa_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int VOICE_COUNT_DEF = 16;
  localparam int CHAN_W          = 4;
  localparam int ORIGIN_W        = 16;

  localparam logic [15:0] LUMP_SILENCE = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_POP     = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ORIGIN_W-1:0]  origin_id;
    logic signed [15:0]   lump;
    logic [14:0]          volume;
    logic signed [15:0]   pan;
  } in_t;

  typedef struct packed {
    logic                 present;
    logic [CHAN_W-1:0]    channel;
    logic signed [15:0]   event_lump;
    logic [14:0]          event_volume;
    logic signed [15:0]   event_pan;
  } out_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    chan;
    logic [15:0]          lump;
    logic [14:0]          vol;
    logic [15:0]          pan;
  } evt_t;

  localparam int EVT_W = $bits(evt_t);

endpackage
`default_nettype wire

@@ hdl/voice_slot_allocator_event_queue.sv @@
// Top level: voice slot allocator with a drop-oldest event queue.
// Start with origin 0 takes the next slot; other origins scan the owner RAM first.
// Stop: owner RAM scan, one compare per cycle. Restart: silence for every voice.
// Pop: empty result on an empty queue, else an event RAM read.
// One transaction in work at a time; pushes go one per cycle into the event RAM.
// Synchronous active-low reset clears pointers, count, owner valid bits and control.
`default_nettype none
module voice_slot_allocator_event_queue
  import vsa_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int IW = $clog2(VOICE_COUNT);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_POP_RD = 4'b0100,
    ST_FILL   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  in_t                  in_r, in_nxt;
  logic [AW-1:0]        rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        nv_r, nv_nxt;
  logic [VOICE_COUNT-1:0] vld_r, vld_nxt;
  logic [IW:0]          scan_idx_r, scan_idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]        fill_idx_r, fill_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic                 acc;
  logic                 ow_we;
  logic [IW-1:0]        ow_addr;
  logic [ORIGIN_W-1:0]  ow_rdata, owner;
  logic                 ev_we;
  evt_t                 ev_wdata, ev_rdata;
  logic [AW-1:0]        ev_raddr;
  logic                 push_en;
  evt_t                 push_evt;
  logic                 start_do, start_found;
  in_t                  start_src;
  logic [IW-1:0]        start_slot;
  logic                 match, scan_end;

  vsa_ram #(.WIDTH(ORIGIN_W), .DEPTH(VOICE_COUNT)) u_owner_ram (
    .clk   (clk),
    .we    (ow_we),
    .waddr (ow_addr),
    .wdata (start_src.origin_id),
    .raddr (scan_idx_r[IW-1:0]),
    .rdata (ow_rdata)
  );

  vsa_ram #(.WIDTH(EVT_W), .DEPTH(QUEUE_DEPTH)) u_event_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (wp_r),
    .wdata (ev_wdata),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE) ||
                     (in_data.op == OP_POP && out_valid_r && out_stall);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign owner    = vld_r[cmp_idx_r] ? ow_rdata : '0;
  assign match    = cmp_v_r && (owner == in_r.origin_id);
  assign scan_end = !cmp_v_r && (scan_idx_r == (IW+1)'(VOICE_COUNT));

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    nv_nxt        = nv_r;
    vld_nxt       = vld_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    fill_idx_nxt  = fill_idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ev_raddr      = rp_r;
    push_en       = 1'b0;
    push_evt      = '0;
    start_do      = 1'b0;
    start_found   = 1'b0;
    start_src     = in_r;
    ow_we         = 1'b0;
    ow_addr       = nv_r;
    ev_we         = 1'b0;
    ev_wdata      = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          in_nxt = in_data;
          case (in_data.op)
            OP_START: begin
              if (in_data.origin_id == '0) begin
                start_do  = 1'b1;
                start_src = in_data;
              end else begin
                state_nxt    = ST_SCAN;
                scan_idx_nxt = '0;
              end
            end
            OP_STOP: begin
              state_nxt    = ST_SCAN;
              scan_idx_nxt = '0;
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
              end else begin
                state_nxt = ST_POP_RD;
                cnt_nxt   = cnt_r - CW'(1);
                if (cnt_r == CW'(1)) begin
                  rp_nxt = '0;
                  wp_nxt = '0;
                end else begin
                  rp_nxt = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
                end
              end
            end
            OP_RESTART: begin
              state_nxt    = ST_FILL;
              vld_nxt      = '0;
              nv_nxt       = '0;
              rp_nxt       = '0;
              wp_nxt       = '0;
              cnt_nxt      = '0;
              fill_idx_nxt = '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx_r < (IW+1)'(VOICE_COUNT)) begin
          cmp_v_nxt    = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IW-1:0];
          scan_idx_nxt = scan_idx_r + (IW+1)'(1);
        end
        if (in_r.op == OP_START) begin
          if (match) begin
            start_do    = 1'b1;
            start_found = 1'b1;
            state_nxt   = ST_IDLE;
          end else if (scan_end) begin
            start_do  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (match) begin
            vld_nxt[cmp_idx_r] = 1'b0;
            push_en            = 1'b1;
            push_evt.chan      = CHAN_W'(32'(cmp_idx_r));
            push_evt.lump      = LUMP_SILENCE;
          end
          if (scan_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_POP_RD: begin
        out_valid_nxt        = 1'b1;
        out_nxt.present      = 1'b1;
        out_nxt.channel      = ev_rdata.chan;
        out_nxt.event_lump   = ev_rdata.lump;
        out_nxt.event_volume = ev_rdata.vol;
        out_nxt.event_pan    = ev_rdata.pan;
        state_nxt            = ST_IDLE;
      end
      ST_FILL: begin
        push_en       = 1'b1;
        push_evt.chan = CHAN_W'(32'(fill_idx_r));
        push_evt.lump = LUMP_SILENCE;
        fill_idx_nxt  = fill_idx_r + IW'(1);
        if (fill_idx_r == IW'(VOICE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_do) begin
      start_slot = start_found ? cmp_idx_r : nv_r;
      if (!start_found) begin
        nv_nxt = (nv_r == IW'(VOICE_COUNT - 1)) ? '0 : nv_r + IW'(1);
      end
      ow_we               = 1'b1;
      ow_addr             = start_slot;
      vld_nxt[start_slot] = 1'b1;
      push_en             = 1'b1;
      push_evt.chan       = CHAN_W'(32'(start_slot));
      push_evt.lump       = start_src.lump;
      push_evt.vol        = start_src.volume;
      push_evt.pan        = start_src.pan;
    end else begin
      start_slot = nv_r;
    end

    if (push_en) begin
      ev_we    = 1'b1;
      ev_wdata = push_evt;
      wp_nxt   = (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (cnt_r == CW'(QUEUE_DEPTH)) begin
        rp_nxt = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      nv_r        <= '0;
      vld_r       <= '0;
      scan_idx_r  <= '0;
      cmp_v_r     <= 1'b0;
      fill_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      nv_r        <= nv_nxt;
      vld_r       <= vld_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      fill_idx_r  <= fill_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_r     <= out_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/vsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sim/tb_voice_slot_allocator_event_queue.sv @@
// Testbench: voice slot allocator with drop-oldest event queue, checked against a shadow model.
`default_nettype none
module tb_voice_slot_allocator_event_queue;
  import vsa_pkg::*;

  localparam int QD = QUEUE_DEPTH_DEF;
  localparam int VC = VOICE_COUNT_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  voice_slot_allocator_event_queue uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // shadow state of the allocator and its queue
  evt_t                shadow_events [QD];
  int unsigned         rd_ptr = 0;
  int unsigned         wr_ptr = 0;
  int unsigned         ev_count = 0;
  int unsigned         next_slot = 0;
  logic [ORIGIN_W-1:0] owner_tag [VC];
  out_t                pop_expect [$];

  bit          idle_on = 1'b1;
  int unsigned fails = 0;
  int unsigned sent = 0;
  int unsigned pops_checked = 0;
  int unsigned drops = 0;

  initial begin
    foreach (owner_tag[i]) owner_tag[i] = '0;
    foreach (shadow_events[i]) shadow_events[i] = '0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("voice_slot_allocator_event_queue verification failed");
    $finish;
  end

  function automatic void queue_event(int unsigned chan, logic [15:0] lump,
                                      logic [14:0] vol, logic [15:0] pan);
    if (ev_count >= QD) begin
      rd_ptr = (rd_ptr + 1) % QD;
      ev_count--;
      drops++;
    end
    shadow_events[wr_ptr].chan = chan[CHAN_W-1:0];
    shadow_events[wr_ptr].lump = lump;
    shadow_events[wr_ptr].vol  = vol;
    shadow_events[wr_ptr].pan  = pan;
    wr_ptr = (wr_ptr + 1) % QD;
    ev_count++;
  endfunction

  function automatic void apply_voice_op(in_t it);
    int unsigned slot;
    bit          found;
    out_t        res;
    evt_t        e;
    case (it.op)
      OP_START: begin
        found = 1'b0;
        slot  = next_slot;
        if (it.origin_id != '0) begin
          for (int i = 0; i < VC; i++) begin
            if (!found && owner_tag[i] == it.origin_id) begin
              slot  = i;
              found = 1'b1;
            end
          end
        end
        if (!found) next_slot = (slot + 1) % VC;
        owner_tag[slot] = it.origin_id;
        queue_event(slot, it.lump, it.volume, it.pan);
      end
      OP_STOP: begin
        for (int i = 0; i < VC; i++) begin
          if (owner_tag[i] == it.origin_id) begin
            owner_tag[i] = '0;
            queue_event(i, LUMP_SILENCE, '0, '0);
          end
        end
      end
      OP_RESTART: begin
        rd_ptr    = 0;
        wr_ptr    = 0;
        ev_count  = 0;
        next_slot = 0;
        foreach (owner_tag[i]) owner_tag[i] = '0;
        for (int i = 0; i < VC; i++) queue_event(i, LUMP_SILENCE, '0, '0);
      end
      default: begin
        res = '0;
        if (ev_count != 0) begin
          e = shadow_events[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QD;
          ev_count--;
          if (ev_count == 0) begin
            rd_ptr = 0;
            wr_ptr = 0;
          end
          res.present      = 1'b1;
          res.channel      = e.chan;
          res.event_lump   = e.lump;
          res.event_volume = e.vol;
          res.event_pan    = e.pan;
        end
        pop_expect.push_back(res);
      end
    endcase
  endfunction

  function automatic in_t voice_cmd(op_t op, logic [15:0] origin, logic [15:0] lump,
                                    logic [14:0] vol, logic [15:0] pan);
    in_t it;
    it.op        = op;
    it.origin_id = origin;
    it.lump      = lump;
    it.volume    = vol;
    it.pan       = pan;
    return it;
  endfunction

  // small origin pool so that reuse and stop matches happen often
  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic in_t random_item(int unsigned pop_pct, int unsigned stop_pct,
                                      int unsigned restart_pct);
    int unsigned r;
    op_t         op;
    logic [15:0] lump;
    r = $urandom_range(0, 99);
    if (r < pop_pct) op = OP_POP;
    else if (r < pop_pct + stop_pct) op = OP_STOP;
    else if (r < pop_pct + stop_pct + restart_pct) op = OP_RESTART;
    else op = OP_START;
    lump = ($urandom_range(0, 7) == 0) ? LUMP_SILENCE : 16'($urandom);
    return voice_cmd(op, pick_origin(), lump, 15'($urandom), 16'($urandom));
  endfunction

  task automatic send_item(in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    apply_voice_op(item);
    sent++;
  endtask

  // receiver backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pop_expect.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        fails++;
      end else begin
        want = pop_expect.pop_front();
        pops_checked++;
        if (out_data.present !== want.present) begin
          $error("present: expected %0d, actual %0d", want.present, out_data.present);
          fails++;
        end
        if (out_data.channel !== want.channel) begin
          $error("channel: expected %0d, actual %0d", want.channel, out_data.channel);
          fails++;
        end
        if (out_data.event_lump !== want.event_lump) begin
          $error("event_lump: expected %0d, actual %0d", want.event_lump, out_data.event_lump);
          fails++;
        end
        if (out_data.event_volume !== want.event_volume) begin
          $error("event_volume: expected %0d, actual %0d",
                 want.event_volume, out_data.event_volume);
          fails++;
        end
        if (out_data.event_pan !== want.event_pan) begin
          $error("event_pan: expected %0d, actual %0d", want.event_pan, out_data.event_pan);
          fails++;
        end
      end
    end
  end

  task automatic test_pop_empty();
    send_item(voice_cmd(OP_POP, 16'h0000, 16'h0000, 15'h0000, 16'h0000));
    send_item(voice_cmd(OP_POP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF));
  endtask

  task automatic test_start_reuse();
    send_item(voice_cmd(OP_START, 16'h0000, 16'h0000, 15'h0000, 16'h8000));
    send_item(voice_cmd(OP_START, 16'h1234, 16'h7FFF, 15'h7FFF, 16'h7FFF));
    send_item(voice_cmd(OP_START, 16'h1234, LUMP_SILENCE, 15'd100, 16'h0000));
    send_item(voice_cmd(OP_START, 16'hFFFF, 16'hFFFE, 15'd1, 16'hFFFF));
    repeat (4) send_item(voice_cmd(OP_POP, 16'h0000, 16'h0000, 15'h0000, 16'h0000));
  endtask

  task automatic test_stop_origin();
    send_item(voice_cmd(OP_START, 16'h00AA, 16'h0123, 15'h2AAA, 16'h5555));
    send_item(voice_cmd(OP_STOP, 16'h00AA, 16'h0000, 15'h0000, 16'h0000));
    send_item(voice_cmd(OP_STOP, 16'h7777, 16'h0000, 15'h0000, 16'h0000));
    send_item(voice_cmd(OP_STOP, 16'h0000, 16'h0000, 15'h0000, 16'h0000));
    repeat (3) send_item(voice_cmd(OP_POP, 16'h0000, 16'h0000, 15'h0000, 16'h0000));
  endtask

  task automatic test_restart();
    send_item(voice_cmd(OP_RESTART, 16'h5A5A, 16'h1111, 15'h1111, 16'h1111));
    repeat (3) send_item(voice_cmd(OP_POP, 16'h0000, 16'h0000, 15'h0000, 16'h0000));
  endtask

  // fill past the queue depth, then drain through empty
  task automatic test_queue_overflow();
    send_item(voice_cmd(OP_RESTART, 16'h0000, 16'h0000, 15'h0000, 16'h0000));
    repeat (30) begin
      send_item(voice_cmd(OP_STOP, 16'h0000, 16'($urandom), 15'($urandom), 16'($urandom)));
      repeat (4) send_item(random_item(0, 0, 0));
    end
    repeat (QD + 12) send_item(voice_cmd(OP_POP, pick_origin(), 16'($urandom),
                                         15'($urandom), 16'($urandom)));
  endtask

  task automatic test_random_mix(int unsigned count);
    repeat (count) send_item(random_item(35, 15, 4));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pop_empty();
    test_start_reuse();
    test_stop_origin();
    test_restart();
    test_queue_overflow();
    test_random_mix(600);
    idle_on = 1'b0;
    test_random_mix(200);
    in_valid <= 1'b0;
    while (pop_expect.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d transactions: start, stop, restart and pop, %0d pop results checked,",
             sent, pops_checked);
    $display("including %0d events dropped on a full queue and pops on an empty one.", drops);
    if (fails == 0 && pop_expect.size() == 0) begin
      $display("voice_slot_allocator_event_queue verification clean");
    end else begin
      $display("voice_slot_allocator_event_queue verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
